// ----- rtl/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  // fixed field widths
  localparam int SUM_W     = 36;  // Q6.30 result sum
  localparam int POS_W     = 3;   // row/column index on the result port
  localparam int DIM_REG_W = 4;   // size register width
  localparam int CFG_AW    = 4;   // APB address width
  localparam int CFG_DW    = 32;  // APB data width

  // input word mode codes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LOAD_A = 2'd0;
  localparam mode_t MODE_LOAD_B = 2'd1;
  localparam mode_t MODE_START  = 2'd2;

  // register indexes (paddr[3:2])
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ROWS  = 2'd0;
  localparam reg_idx_t REG_INNER = 2'd1;
  localparam reg_idx_t REG_COLS  = 2'd2;

  // store write commands, controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic clear_fill;
  } load_cmd_t;

  // one multiply-accumulate step, controller to datapath
  typedef struct packed {
    logic             rd;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } step_cmd_t;

endpackage

// ----- rtl/mme_ram.sv -----
// ----------------------------------------------------------------------------
// mme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mme_cfg.sv -----
// ----------------------------------------------------------------------------
// mme_cfg
// APB register file for the matrix sizes M, K and N; clamps them to 1..MAX_DIM.
// ----------------------------------------------------------------------------
module mme_cfg
  import mme_pkg::*;
#(
  parameter int MAX_DIM = 8,
  localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [DIM_W-1:0]  m_eff,
  output logic [DIM_W-1:0]  k_eff,
  output logic [DIM_W-1:0]  n_eff
);

  localparam logic [DIM_REG_W-1:0] DIM_RST = DIM_REG_W'(8);

  logic [DIM_REG_W-1:0] rows_r, inner_r, cols_r;
  logic                 wr_en;
  reg_idx_t             idx;

  // zero acts as one, oversize acts as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] raw);
    logic [DIM_W-1:0] r;
    if (raw == '0) begin
      r = DIM_W'(1);
    end else if (raw > DIM_REG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(raw);
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_RST;
      inner_r <= DIM_RST;
      cols_r  <= DIM_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROWS:  rows_r  <= pwdata[DIM_REG_W-1:0];
        REG_INNER: inner_r <= pwdata[DIM_REG_W-1:0];
        REG_COLS:  cols_r  <= pwdata[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_ROWS:  prdata = CFG_DW'(rows_r);
      REG_INNER: prdata = CFG_DW'(inner_r);
      REG_COLS:  prdata = CFG_DW'(cols_r);
      default:   prdata = '0;
    endcase
  end

  assign m_eff = eff_dim(rows_r);
  assign k_eff = eff_dim(inner_r);
  assign n_eff = eff_dim(cols_r);

endmodule

// ----- rtl/mme_ctrl.sv -----
// ----------------------------------------------------------------------------
// mme_ctrl
// Controller: decodes input words, walks i/j/k for a compute run and issues
// one store read step per cycle to the datapath.
// ----------------------------------------------------------------------------
module mme_ctrl
  import mme_pkg::*;
#(
  parameter int MAX_DIM = 8,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mode_t             mode,
  input  logic [DIM_W-1:0]  m_eff,
  input  logic [DIM_W-1:0]  k_eff,
  input  logic [DIM_W-1:0]  n_eff,
  input  logic              pipe_busy,
  output logic              busy,
  output load_cmd_t         load_cmd,
  output step_cmd_t         step_cmd,
  output logic [ADDR_W-1:0] a_addr,
  output logic [ADDR_W-1:0] b_addr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [ADDR_W-1:0] a_addr_r, a_addr_nxt, b_addr_r, b_addr_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [ADDR_W-1:0] step_a_r, step_a_nxt, step_b_r, step_b_nxt;
  step_cmd_t         step_r, step_nxt;
  logic              accept, i_last, j_last, k_last;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign i_last = (i_r == m_eff - DIM_W'(1));
  assign j_last = (j_r == n_eff - DIM_W'(1));
  assign k_last = (k_r == k_eff - DIM_W'(1));

  // load commands act in the accepting cycle
  assign load_cmd.load_a     = accept && (mode == MODE_LOAD_A);
  assign load_cmd.load_b     = accept && (mode == MODE_LOAD_B);
  assign load_cmd.clear_fill = accept && (mode == MODE_START);

  // sequencer: k innermost, then j, then i
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    row_base_nxt = row_base_r;
    step_a_nxt   = step_a_r;
    step_b_nxt   = step_b_r;
    step_nxt     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (mode == MODE_START)) begin
          state_nxt    = S_RUN;
          i_nxt        = '0;
          j_nxt        = '0;
          k_nxt        = '0;
          a_addr_nxt   = '0;
          b_addr_nxt   = '0;
          row_base_nxt = '0;
        end
      end
      S_RUN: begin
        step_nxt.rd        = 1'b1;
        step_nxt.first     = (k_r == '0);
        step_nxt.last_k    = k_last;
        step_nxt.last_elem = i_last && j_last;
        step_nxt.row       = POS_W'(i_r);
        step_nxt.col       = POS_W'(j_r);
        step_a_nxt         = a_addr_r;
        step_b_nxt         = b_addr_r;
        if (!k_last) begin
          k_nxt      = k_r + DIM_W'(1);
          a_addr_nxt = a_addr_r + ADDR_W'(1);
          b_addr_nxt = b_addr_r + ADDR_W'(n_eff);
        end else begin
          k_nxt = '0;
          if (!j_last) begin
            j_nxt      = j_r + DIM_W'(1);
            a_addr_nxt = row_base_r;
            b_addr_nxt = ADDR_W'(j_r) + ADDR_W'(1);
          end else begin
            j_nxt      = '0;
            b_addr_nxt = '0;
            if (!i_last) begin
              i_nxt        = i_r + DIM_W'(1);
              row_base_nxt = row_base_r + ADDR_W'(k_eff);
              a_addr_nxt   = row_base_r + ADDR_W'(k_eff);
            end else begin
              state_nxt = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        if (!step_r.rd && !pipe_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, counters and registered step command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= '0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      a_addr_r   <= '0;
      b_addr_r   <= '0;
      row_base_r <= '0;
      step_a_r   <= '0;
      step_b_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
      a_addr_r   <= a_addr_nxt;
      b_addr_r   <= b_addr_nxt;
      row_base_r <= row_base_nxt;
      step_a_r   <= step_a_nxt;
      step_b_r   <= step_b_nxt;
    end
  end

  assign step_cmd = step_r;
  assign a_addr   = step_a_r;
  assign b_addr   = step_b_r;

  // a compute word always takes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (mode == MODE_START)) |=> busy)
    else $error("compute word did not start a run");

  // issued read addresses stay inside the stores
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r.rd |-> ((32'(step_a_r) < DEPTH) && (32'(step_b_r) < DEPTH)))
    else $error("store read address out of range");

  // inner counter stays below K while running
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (k_r < k_eff))
    else $error("inner counter out of range");

  // no step in flight from the controller once idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !step_r.rd)
    else $error("step issued while idle");

endmodule

// ----- rtl/mme_dp.sv -----
// ----------------------------------------------------------------------------
// mme_dp
// Datapath: A and B stores with fill counters and valid bits, then a
// read / multiply / accumulate pipeline and the result register.
// ----------------------------------------------------------------------------
module mme_dp
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [DATA_WIDTH-1:0] element,
  input  load_cmd_t                    load_cmd,
  input  step_cmd_t                    step_cmd,
  input  logic        [ADDR_W-1:0]     a_addr,
  input  logic        [ADDR_W-1:0]     b_addr,
  output logic                         pipe_busy,
  output logic                         out_valid,
  output logic signed [SUM_W-1:0]      out_product_sum,
  output logic        [POS_W-1:0]      out_row_index,
  output logic        [POS_W-1:0]      out_col_index,
  output logic                         out_last
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PROD_W = 2 * DATA_WIDTH;

  logic [CNT_W-1:0]  a_cnt_r, b_cnt_r;
  logic [DEPTH-1:0]  a_vld_r, b_vld_r;
  logic              a_we, b_we;
  logic [DATA_WIDTH-1:0] a_rdata, b_rdata;
  logic              a_vld_q, b_vld_q;
  step_cmd_t         s1_r, s2_r;
  logic signed [DATA_WIDTH-1:0] a_op, b_op;
  logic signed [PROD_W-1:0]     prod_nxt, prod_r;
  logic signed [SUM_W-1:0]      prod_ext;
  logic [SUM_W-1:0]  acc_r, sum_nxt;
  logic              out_valid_r, out_last_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic [POS_W-1:0]  out_row_r, out_col_r;

  // store writes while not full
  assign a_we = load_cmd.load_a && (a_cnt_r < CNT_W'(DEPTH));
  assign b_we = load_cmd.load_b && (b_cnt_r < CNT_W'(DEPTH));

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_cnt_r[ADDR_W-1:0]),
    .wdata (element),
    .re    (step_cmd.rd),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_cnt_r[ADDR_W-1:0]),
    .wdata (element),
    .re    (step_cmd.rd),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  // fill counters and per-entry valid bits (unwritten entries read as zero)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      a_vld_r <= '0;
      b_vld_r <= '0;
    end else begin
      if (load_cmd.clear_fill) begin
        a_cnt_r <= '0;
        b_cnt_r <= '0;
      end else begin
        if (a_we) begin
          a_cnt_r <= a_cnt_r + CNT_W'(1);
          a_vld_r[a_cnt_r[ADDR_W-1:0]] <= 1'b1;
        end
        if (b_we) begin
          b_cnt_r <= b_cnt_r + CNT_W'(1);
          b_vld_r[b_cnt_r[ADDR_W-1:0]] <= 1'b1;
        end
      end
    end
  end

  // stage 1: read data and valid bits arrive
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= step_cmd;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_cmd.rd) begin
      a_vld_q <= a_vld_r[a_addr];
      b_vld_q <= b_vld_r[b_addr];
    end
  end

  assign a_op = a_vld_q ? signed'(a_rdata) : '0;
  assign b_op = b_vld_q ? signed'(b_rdata) : '0;

  // stage 2: product register
  assign prod_nxt = a_op * b_op;

  always_ff @(posedge clk) begin
    if (s1_r.rd) begin
      prod_r <= prod_nxt;
    end
  end

  // stage 3: accumulate, wraps modulo 2^36
  assign prod_ext = SUM_W'(prod_r);
  assign sum_nxt  = (s2_r.first ? '0 : acc_r) + prod_ext;

  always_ff @(posedge clk) begin
    if (s2_r.rd) begin
      acc_r <= sum_nxt;
    end
    if (s2_r.rd && s2_r.last_k) begin
      out_sum_r  <= sum_nxt;
      out_row_r  <= s2_r.row;
      out_col_r  <= s2_r.col;
      out_last_r <= s2_r.last_elem;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_r.rd && s2_r.last_k;
    end
  end

  assign pipe_busy       = s1_r.rd || s2_r.rd;
  assign out_valid       = out_valid_r;
  assign out_product_sum = signed'(out_sum_r);
  assign out_row_index   = out_row_r;
  assign out_col_index   = out_col_r;
  assign out_last        = out_last_r;

endmodule

// ----- rtl/matrix_multiply_engine_unit.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit
// C = A x B on signed Q1.15 elements with exact Q6.30 sums.
//
// Usage:
//  - Input words are taken when start is high and busy is low. Mode load A
//    and load B write the next element of A or B (row-major) and leave
//    busy low, so loads stream at one word per cycle.
//  - A compute word raises busy and emits all M*N results in row-major
//    order, one per out_valid pulse, out_last on the final one; it rewinds
//    both fill counters. Stores keep their contents across runs.
//  - One MAC step per cycle through a single multiplier; each step passes
//    the read, product and accumulate stages, and each result is then
//    held in the result register.
//  - M, K, N are APB registers at 0x0, 0x4, 0x8; write them only while idle.
//  - Results are strobed for one cycle and cannot be held off.
//  - Reset: sizes to 8, fill counters cleared, store entries read as zero
//    until written; the block accepts words as soon as reset is released.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         start,
  output logic                         busy,
  input  logic        [1:0]            in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_element,
  // result channel
  output logic                         out_valid,
  output logic signed [SUM_W-1:0]      out_product_sum,
  output logic        [POS_W-1:0]      out_row_index,
  output logic        [POS_W-1:0]      out_col_index,
  output logic                         out_last,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic        [CFG_AW-1:0]     paddr,
  input  logic        [CFG_DW-1:0]     pwdata,
  output logic        [CFG_DW-1:0]     prdata,
  output logic                         pready
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0]  m_eff, k_eff, n_eff;
  load_cmd_t         load_cmd;
  step_cmd_t         step_cmd;
  logic [ADDR_W-1:0] a_addr, b_addr;
  logic              pipe_busy;

  mme_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .m_eff   (m_eff),
    .k_eff   (k_eff),
    .n_eff   (n_eff)
  );

  mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .mode      (in_mode),
    .m_eff     (m_eff),
    .k_eff     (k_eff),
    .n_eff     (n_eff),
    .pipe_busy (pipe_busy),
    .busy      (busy),
    .load_cmd  (load_cmd),
    .step_cmd  (step_cmd),
    .a_addr    (a_addr),
    .b_addr    (b_addr)
  );

  mme_dp #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .element         (in_element),
    .load_cmd        (load_cmd),
    .step_cmd        (step_cmd),
    .a_addr          (a_addr),
    .b_addr          (b_addr),
    .pipe_busy       (pipe_busy),
    .out_valid       (out_valid),
    .out_product_sum (out_product_sum),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_last        (out_last)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for matrix_multiply_engine_unit. A driver streams load
// and compute words from a queue. A local GEMM predictor mirrors both stores,
// the fill counters and the size registers, and queues every C element a
// compute word should produce. The monitor checks each strobed result against
// the oldest queued element. Sizes are changed over APB between phases, once
// the block has gone idle.
// ----------------------------------------------------------------------------
module tb_top;
  import mme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM     = 8;
  localparam int DW          = 16;
  localparam int DEPTH       = MAX_DIM * MAX_DIM;
  localparam int STALL_LIMIT = 3000;
  localparam int RAND_WORDS  = 85;
  localparam int MAX_REPORTS = 10;

  // mode code the block must ignore
  localparam mode_t MODE_SPARE = 2'd3;

  typedef struct {
    mode_t                mode;
    logic signed [DW-1:0] elem;
  } word_t;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } c_elem_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  mode_t                    in_mode = MODE_LOAD_A;
  logic signed [DW-1:0]     in_element = '0;
  logic                     out_valid;
  logic signed [SUM_W-1:0]  out_product_sum;
  logic        [POS_W-1:0]  out_row_index;
  logic        [POS_W-1:0]  out_col_index;
  logic                     out_last;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic        [CFG_AW-1:0] paddr = '0;
  logic        [CFG_DW-1:0] pwdata = '0;
  logic        [CFG_DW-1:0] prdata;
  logic                     pready;

  matrix_multiply_engine_unit #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DW)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_element      (in_element),
    .out_valid       (out_valid),
    .out_product_sum (out_product_sum),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // GEMM predictor: mirrored stores, fill counters and size registers
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] a_mirror [DEPTH];
  logic signed [DW-1:0] b_mirror [DEPTH];
  int                   a_fill = 0;
  int                   b_fill = 0;
  logic [DIM_REG_W-1:0] size_m = 4'd8;
  logic [DIM_REG_W-1:0] size_k = 4'd8;
  logic [DIM_REG_W-1:0] size_n = 4'd8;

  word_t   words_to_send [$];
  c_elem_t c_elems_due [$];
  int      n_bad = 0;

  // zero and oversize register values clamp to the legal range
  function automatic int eff_dim(logic [DIM_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  // apply one accepted word; a compute word queues every C element
  task automatic absorb_word(mode_t md, logic signed [DW-1:0] el);
    int      m, kk, n;
    longint  acc;
    c_elem_t ce;
    case (md)
      MODE_LOAD_A: begin
        if (a_fill < DEPTH) begin
          a_mirror[a_fill] = el;
          a_fill++;
        end
      end
      MODE_LOAD_B: begin
        if (b_fill < DEPTH) begin
          b_mirror[b_fill] = el;
          b_fill++;
        end
      end
      MODE_START: begin
        m  = eff_dim(size_m);
        kk = eff_dim(size_k);
        n  = eff_dim(size_n);
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < kk; k++) begin
              acc += longint'(a_mirror[(i * kk + k) % DEPTH]) *
                     longint'(b_mirror[(k * n + j) % DEPTH]);
            end
            ce.sum  = acc[SUM_W-1:0];
            ce.row  = POS_W'(i);
            ce.col  = POS_W'(j);
            ce.last = (i == m - 1) && (j == n - 1);
            c_elems_due.push_back(ce);
          end
        end
        a_fill = 0;
        b_fill = 0;
      end
      default: ;  // spare mode: no effect
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: holds start until the word is taken, then idles a random gap
  // --------------------------------------------------------------------------
  int gap_left   = 0;
  int burst_left = 0;

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        // word taken at this edge
        absorb_word(in_mode, in_element);
        void'(words_to_send.pop_front());
        gap_left = next_gap();
      end
      if (gap_left > 0 || words_to_send.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        start      <= 1'b1;
        in_mode    <= words_to_send[0].mode;
        in_element <= words_to_send[0].elem;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobed result against the oldest expected C element
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    c_elem_t ce;
    if (rst_n && out_valid) begin
      if (c_elems_due.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("unexpected result: sum=%h row=%0d col=%0d last=%0b",
                   out_product_sum, out_row_index, out_col_index, out_last);
      end else begin
        ce = c_elems_due.pop_front();
        if (ce.sum !== out_product_sum || ce.row !== out_row_index ||
            ce.col !== out_col_index || ce.last !== out_last) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("mismatch: exp sum=%h row=%0d col=%0d last=%0b / got sum=%h row=%0d col=%0d last=%0b",
                     ce.sum, ce.row, ce.col, ce.last,
                     out_product_sum, out_row_index, out_col_index, out_last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles in a row with no word, result or register write
  // --------------------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pwrite)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  int rand_words = 0;

  task automatic push_word(mode_t md, logic signed [DW-1:0] el);
    word_t w;
    w.mode = md;
    w.elem = el;
    words_to_send.push_back(w);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic cfg_write(reg_idx_t idx, logic [DIM_REG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROWS:  size_m = val;
      REG_INNER: size_k = val;
      REG_COLS:  size_n = val;
      default: ;
    endcase
  endtask

  task automatic set_sizes(logic [DIM_REG_W-1:0] m, logic [DIM_REG_W-1:0] k,
                           logic [DIM_REG_W-1:0] n);
    cfg_write(REG_ROWS, m);
    cfg_write(REG_INNER, k);
    cfg_write(REG_COLS, n);
    @(negedge clk);
  endtask

  // wait until every word is taken and every result is in, then let the
  // pipeline run dry before touching the registers again
  task automatic drain();
    do @(negedge clk);
    while (words_to_send.size() != 0 || start || busy || c_elems_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_elem();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    return DW'($urandom);
  endfunction

  // mostly small sizes, some large, some out of range
  function automatic logic [DIM_REG_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return DIM_REG_W'($urandom_range(1, 3));
    if (r < 17) return DIM_REG_W'($urandom_range(4, 8));
    if ($urandom_range(0, 1) == 0) return '0;
    return DIM_REG_W'($urandom_range(9, 15));
  endfunction

  // na A loads and nb B loads, optionally interleaved and salted with spare
  // mode words, then one compute word
  task automatic load_and_run(int na, int nb, bit mix, int noise_pct);
    while (na > 0 || nb > 0) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        push_word(MODE_SPARE, rand_elem());
        rand_words++;
      end
      if (nb == 0 || (na > 0 && (!mix || $urandom_range(0, 1) == 0))) begin
        push_word(MODE_LOAD_A, rand_elem());
        na--;
      end else begin
        push_word(MODE_LOAD_B, rand_elem());
        nb--;
      end
      rand_words++;
    end
    push_word(MODE_START, rand_elem());
    rand_words++;
  endtask

  task automatic random_phase();
    int na, nb, kind;
    set_sizes(pick_size(), pick_size(), pick_size());
    na   = eff_dim(size_m) * eff_dim(size_k);
    nb   = eff_dim(size_k) * eff_dim(size_n);
    kind = $urandom_range(0, 9);
    case (kind)
      7:       load_and_run($urandom_range(0, na), $urandom_range(0, nb), 1'b1, 0);
      8:       load_and_run(na, nb, 1'b1, 25);
      9:       load_and_run(na + $urandom_range(1, 4), nb + $urandom_range(1, 4), 1'b1, 0);
      default: load_and_run(na, nb, kind[0], 0);
    endcase
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    bit flooded;
    flooded = 1'b0;
    for (int x = 0; x < DEPTH; x++) begin
      a_mirror[x] = '0;
      b_mirror[x] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset sizes on cleared stores; spare mode word first
    push_word(MODE_SPARE, 16'sh5a5a);
    push_word(MODE_START, 16'sh7fff);
    drain();

    // 1x1x1: extreme products, then a rerun on stale stores
    set_sizes(4'd1, 4'd1, 4'd1);
    push_word(MODE_LOAD_A, 16'sh8000);
    push_word(MODE_LOAD_B, 16'sh8000);
    push_word(MODE_START, 16'sh0000);
    push_word(MODE_LOAD_A, 16'sh7fff);
    push_word(MODE_LOAD_B, 16'sh8000);
    push_word(MODE_START, 16'shffff);
    push_word(MODE_LOAD_A, 16'sh7fff);
    push_word(MODE_LOAD_B, 16'sh7fff);
    push_word(MODE_START, 16'sh8000);
    push_word(MODE_SPARE, 16'sha5a5);
    push_word(MODE_START, 16'sh0001);
    drain();

    // 2x2x2 of the most negative value: largest positive sums
    set_sizes(4'd2, 4'd2, 4'd2);
    repeat (4) push_word(MODE_LOAD_A, 16'sh8000);
    repeat (4) push_word(MODE_LOAD_B, 16'sh8000);
    push_word(MODE_START, 16'sh0000);
    drain();

    // out-of-range sizes clamp; both runs use stale store contents
    set_sizes(4'd0, 4'd15, 4'd0);
    push_word(MODE_START, 16'sh0000);
    drain();
    set_sizes(4'd15, 4'd0, 4'd15);
    push_word(MODE_START, 16'sh0000);
    drain();

    // random phases; one early run overfills the A or the B store
    while (rand_words < RAND_WORDS) begin
      if (!flooded && rand_words >= RAND_WORDS / 8) begin
        if ($urandom_range(0, 1) == 0) begin
          set_sizes(4'd8, 4'd8, 4'd1);
          load_and_run(DEPTH + 2, MAX_DIM, 1'b1, 0);
        end else begin
          set_sizes(4'd1, 4'd8, 4'd8);
          load_and_run(MAX_DIM, DEPTH + 2, 1'b1, 0);
        end
        drain();
        flooded = 1'b1;
      end else begin
        random_phase();
      end
    end

    drain();
    if (n_bad == 0 && c_elems_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
